// File: rtl/core/ata_tf_pkg.sv
// types, register codes and opcode selection shared by the task-file command issuer
package ata_tf_pkg;

   // request codes
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;

   // task-file register targets
   localparam logic [3:0] REG_COUNT   = 4'd2;
   localparam logic [3:0] REG_LBA_LO  = 4'd3;
   localparam logic [3:0] REG_LBA_MID = 4'd4;
   localparam logic [3:0] REG_LBA_HI  = 4'd5;
   localparam logic [3:0] REG_DEVICE  = 4'd6;
   localparam logic [3:0] REG_COMMAND = 4'd7;
   localparam logic [3:0] REG_CONTROL = 4'd8;

   // device byte and opcodes
   localparam logic [7:0] DEVICE_BASE      = 8'he0;
   localparam logic [7:0] OP_READ_PIO      = 8'h20;
   localparam logic [7:0] OP_READ_PIO_EXT  = 8'h24;
   localparam logic [7:0] OP_WRITE_PIO     = 8'h30;
   localparam logic [7:0] OP_WRITE_PIO_EXT = 8'h34;
   localparam logic [7:0] OP_READ_DMA      = 8'hc8;
   localparam logic [7:0] OP_READ_DMA_EXT  = 8'h25;
   localparam logic [7:0] OP_WRITE_DMA     = 8'hca;
   localparam logic [7:0] OP_WRITE_DMA_EXT = 8'h35;
   localparam logic [7:0] OP_FLUSH         = 8'he7;

   // longest sequence and the widths of its counters
   localparam int BEAT_MAX = 10;
   localparam int IDX_W    = $clog2(BEAT_MAX);
   localparam int LEN_W    = $clog2(BEAT_MAX + 1);

   typedef struct packed {
      logic [1:0]  cmd;
      logic        drive_select;
      logic [47:0] lba;
      logic [16:0] num_sectors;
   } req_type;

   typedef struct packed {
      logic [3:0] target;
      logic [7:0] value;
      logic       last;
   } rsp_type;

   // one decoded request: its beats in order and how many there are
   typedef struct packed {
      logic [LEN_W-1:0]             len;
      rsp_type [BEAT_MAX-1:0]       beats;
   } seq_type;

   function automatic rsp_type make_beat(input logic [3:0] target, input logic [7:0] value,
                                         input logic last);
      rsp_type b;
      b.target = target;
      b.value  = value;
      b.last   = last;
      return b;
   endfunction

   function automatic logic [7:0] pick_opcode(input logic is_write, input logic use_dma,
                                              input logic ext);
      logic [7:0] op;
      if (use_dma) begin
         if (is_write) op = ext ? OP_WRITE_DMA_EXT : OP_WRITE_DMA;
         else          op = ext ? OP_READ_DMA_EXT  : OP_READ_DMA;
      end else begin
         if (is_write) op = ext ? OP_WRITE_PIO_EXT : OP_WRITE_PIO;
         else          op = ext ? OP_READ_PIO_EXT  : OP_READ_PIO;
      end
      return op;
   endfunction

endpackage

// File: rtl/core/ata_tf_builder.sv
// decodes one request into its ordered list of task-file register writes
module ata_tf_builder
   import ata_tf_pkg::*;
(
   input  req_type req,
   input  logic    dma_mode,
   output seq_type seq
);

   logic       ext;
   logic       count_big;
   logic [7:0] dev;
   logic [7:0] op;

   // lba48 when the address needs more than 28 bits or the count exceeds 256
   assign count_big = (req.num_sectors[16:9] != 8'd0) ||
                      (req.num_sectors[8] && (req.num_sectors[7:0] != 8'd0));
   assign ext = (req.lba[47:28] != 20'd0) || count_big;
   assign dev = DEVICE_BASE | {3'b000, req.drive_select, 4'b0000};
   assign op  = pick_opcode(req.cmd == CMD_WRITE, dma_mode, ext);

   // beat list
   always_comb begin
      seq.len   = '0;
      seq.beats = '0;
      case (req.cmd)
         CMD_FLUSH: begin
            seq.len      = LEN_W'(3);
            seq.beats[0] = make_beat(REG_CONTROL, 8'h00, 1'b0);
            seq.beats[1] = make_beat(REG_DEVICE, dev, 1'b0);
            seq.beats[2] = make_beat(REG_COMMAND, OP_FLUSH, 1'b1);
         end
         CMD_READ, CMD_WRITE: begin
            if (ext) begin
               seq.len      = LEN_W'(10);
               seq.beats[0] = make_beat(REG_DEVICE, dev, 1'b0);
               seq.beats[1] = make_beat(REG_COUNT, req.num_sectors[15:8], 1'b0);
               seq.beats[2] = make_beat(REG_LBA_LO, req.lba[31:24], 1'b0);
               seq.beats[3] = make_beat(REG_LBA_MID, req.lba[39:32], 1'b0);
               seq.beats[4] = make_beat(REG_LBA_HI, req.lba[47:40], 1'b0);
               seq.beats[5] = make_beat(REG_COUNT, req.num_sectors[7:0], 1'b0);
               seq.beats[6] = make_beat(REG_LBA_LO, req.lba[7:0], 1'b0);
               seq.beats[7] = make_beat(REG_LBA_MID, req.lba[15:8], 1'b0);
               seq.beats[8] = make_beat(REG_LBA_HI, req.lba[23:16], 1'b0);
               seq.beats[9] = make_beat(REG_COMMAND, op, 1'b1);
            end else begin
               // a full count of 256 falls out as 0 in the low byte
               seq.len      = LEN_W'(7);
               seq.beats[0] = make_beat(REG_CONTROL, 8'h00, 1'b0);
               seq.beats[1] = make_beat(REG_DEVICE, dev | {4'b0000, req.lba[27:24]}, 1'b0);
               seq.beats[2] = make_beat(REG_COUNT, req.num_sectors[7:0], 1'b0);
               seq.beats[3] = make_beat(REG_LBA_LO, req.lba[7:0], 1'b0);
               seq.beats[4] = make_beat(REG_LBA_MID, req.lba[15:8], 1'b0);
               seq.beats[5] = make_beat(REG_LBA_HI, req.lba[23:16], 1'b0);
               seq.beats[6] = make_beat(REG_COMMAND, op, 1'b1);
            end
         end
         default: begin
            seq.len = '0;
         end
      endcase
   end

endmodule

// File: rtl/core/ata_tf_sequencer.sv
// holds the decoded beat list and sends one beat per cycle through the result register
module ata_tf_sequencer
   import ata_tf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  seq_type seq,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   seq_type          seq_ff,    seq_in;
   logic [IDX_W-1:0] idx_ff,    idx_in;
   logic             active_ff, active_in;
   logic             strobe_ff, strobe_in;
   rsp_type          beat_ff,   beat_in;

   logic final_beat;
   logic accept;

   // the final beat leaves this cycle, so a new request may enter
   assign final_beat = active_ff && (LEN_W'(idx_ff) == seq_ff.len - LEN_W'(1));
   assign busy       = active_ff && !final_beat;
   assign accept     = start && !busy;

   // next state
   always_comb begin
      seq_in    = seq_ff;
      idx_in    = idx_ff;
      active_in = active_ff;
      strobe_in = active_ff;
      beat_in   = active_ff ? seq_ff.beats[idx_ff] : beat_ff;
      if (accept) begin
         seq_in    = seq;
         idx_in    = '0;
         active_in = (seq.len != '0);
      end else if (active_ff) begin
         if (final_beat) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
      seq_ff  <= seq_in;
      idx_ff  <= idx_in;
      beat_ff <= beat_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = beat_ff;

endmodule

// File: rtl/core/ata_taskfile_command_issuer.sv
// top level of the ata task-file command issuer
// A request is taken at a clock edge where start is high and busy is low; it
// becomes 3 (flush), 7 (lba28) or 10 (lba48) register-write beats, one per
// cycle on rsp_strobe/rsp_payload; the beat list is registered and each beat
// then passes through the result register. The single result register sets
// the rate: one beat per cycle, and the next request is taken in the cycle
// its predecessor's final beat is loaded. An unused command code yields no
// beats and leaves busy low. The receiver cannot stall: every beat is valid
// for exactly one cycle and must be taken. The user writes dma_mode through
// csr_write_enable/csr_write_data only while idle, not enforced by the block.
module ata_taskfile_command_issuer
   import ata_tf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload,
   input  logic    csr_write_enable,
   input  logic    csr_write_data
);

   logic    dma_mode_ff, dma_mode_in;
   seq_type seq;

   // dma mode register
   assign dma_mode_in = csr_write_enable ? csr_write_data : dma_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dma_mode_ff <= 1'b0;
      end else begin
         dma_mode_ff <= dma_mode_in;
      end
   end

   // request decode
   ata_tf_builder u_builder (
      .req      (req_payload),
      .dma_mode (dma_mode_ff),
      .seq      (seq)
   );

   // beat sequencing
   ata_tf_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .seq         (seq),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the ata task-file command issuer: directed and random requests
module testbench;
   import ata_tf_pkg::*;

   localparam logic [1:0]  CMD_UNUSED    = 2'd3;
   localparam logic [47:0] LBA28_LAST    = 48'h0000_0fff_ffff;
   localparam logic [47:0] LBA_TOP       = 48'hffff_ffff_ffff;
   localparam logic [16:0] COUNT28_LAST  = 17'd256;
   localparam logic [16:0] COUNT_FULL    = 17'h10000;
   localparam logic [16:0] COUNT_TOP     = 17'h1ffff;
   localparam int          BEATS_FLUSH   = 3;
   localparam int          BEATS_LBA28   = 7;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          REPORT_LIMIT  = 10;
   localparam int          RANDOM_ITEMS  = 60;
   localparam int          BURST_ITEMS   = 12;

   logic    clock            = 1'b0;
   logic    reset            = 1'b1;
   logic    start            = 1'b0;
   req_type req_payload      = '0;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data   = 1'b0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   // model copy of the mode register and the beats still owed by the block
   logic    dma_mode_model = 1'b0;
   rsp_type pending_writes[$];

   int error_count   = 0;
   int beats_checked = 0;
   int lba28_count   = 0;
   int lba48_count   = 0;
   int flush_count   = 0;
   int ignored_count = 0;

   ata_taskfile_command_issuer dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   task automatic note_failure(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%0t mismatch: %s", $time, what);
   endtask

   function automatic rsp_type taskfile_write(input logic [3:0] target, input logic [7:0] value,
                                              input logic last);
      rsp_type w;
      w.target = target;
      w.value  = value;
      w.last   = last;
      return w;
   endfunction

   // opcode from direction, transfer mode and addressing mode
   function automatic logic [7:0] transfer_opcode(input logic is_write, input logic use_dma,
                                                  input logic ext);
      logic [7:0] op;
      case ({use_dma, is_write, ext})
         3'b000: op = OP_READ_PIO;
         3'b001: op = OP_READ_PIO_EXT;
         3'b010: op = OP_WRITE_PIO;
         3'b011: op = OP_WRITE_PIO_EXT;
         3'b100: op = OP_READ_DMA;
         3'b101: op = OP_READ_DMA_EXT;
         3'b110: op = OP_WRITE_DMA;
         default: op = OP_WRITE_DMA_EXT;
      endcase
      return op;
   endfunction

   // expand one request into its register writes, appended to the pending queue
   function automatic int queue_taskfile_writes(input req_type r, input logic use_dma);
      logic [7:0] dev;
      logic       ext;
      int         before_size;
      before_size = pending_writes.size();
      dev = DEVICE_BASE | {3'b000, r.drive_select, 4'h0};
      if (r.cmd == CMD_FLUSH) begin
         pending_writes.push_back(taskfile_write(REG_CONTROL, 8'h00, 1'b0));
         pending_writes.push_back(taskfile_write(REG_DEVICE, dev, 1'b0));
         pending_writes.push_back(taskfile_write(REG_COMMAND, OP_FLUSH, 1'b1));
      end else if (r.cmd != CMD_UNUSED) begin
         ext = (r.lba > LBA28_LAST) || (r.num_sectors > COUNT28_LAST);
         if (ext) begin
            // high bytes first, no device control write
            pending_writes.push_back(taskfile_write(REG_DEVICE, dev, 1'b0));
            pending_writes.push_back(taskfile_write(REG_COUNT, r.num_sectors[15:8], 1'b0));
            pending_writes.push_back(taskfile_write(REG_LBA_LO, r.lba[31:24], 1'b0));
            pending_writes.push_back(taskfile_write(REG_LBA_MID, r.lba[39:32], 1'b0));
            pending_writes.push_back(taskfile_write(REG_LBA_HI, r.lba[47:40], 1'b0));
            pending_writes.push_back(taskfile_write(REG_COUNT, r.num_sectors[7:0], 1'b0));
         end else begin
            pending_writes.push_back(taskfile_write(REG_CONTROL, 8'h00, 1'b0));
            pending_writes.push_back(taskfile_write(REG_DEVICE, dev | {4'h0, r.lba[27:24]},
                                                    1'b0));
            pending_writes.push_back(taskfile_write(REG_COUNT, r.num_sectors[7:0], 1'b0));
         end
         pending_writes.push_back(taskfile_write(REG_LBA_LO, r.lba[7:0], 1'b0));
         pending_writes.push_back(taskfile_write(REG_LBA_MID, r.lba[15:8], 1'b0));
         pending_writes.push_back(taskfile_write(REG_LBA_HI, r.lba[23:16], 1'b0));
         pending_writes.push_back(taskfile_write(REG_COMMAND,
                                                 transfer_opcode(r.cmd == CMD_WRITE, use_dma,
                                                                 ext), 1'b1));
      end
      return pending_writes.size() - before_size;
   endfunction

   function automatic req_type build_request(input logic [1:0] cmd, input logic drive,
                                             input logic [47:0] lba, input logic [16:0] count);
      req_type r;
      r.cmd          = cmd;
      r.drive_select = drive;
      r.lba          = lba;
      r.num_sectors  = count;
      return r;
   endfunction

   // mostly well-formed transfers, with flushes, odd counts and unused codes mixed in
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      r.cmd          = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
      r.drive_select = 1'($urandom_range(0, 1));
      r.lba          = {16'($urandom), 32'($urandom)};
      r.num_sectors  = 17'($urandom_range(1, 65536));
      if (pick < 5) begin
         r.cmd = CMD_UNUSED;
      end else if (pick < 15) begin
         r.cmd = CMD_FLUSH;
      end else if (pick < 55) begin
         r.lba         = r.lba & LBA28_LAST;
         r.num_sectors = 17'($urandom_range(1, 256));
      end else if (pick < 80) begin
         r.lba[28 + $urandom_range(0, 19)] = 1'b1;
      end else if (pick < 90) begin
         r.lba         = r.lba & LBA28_LAST;
         r.num_sectors = 17'($urandom_range(257, 65536));
      end else if (pick < 95) begin
         if ($urandom_range(0, 1)) r.lba = r.lba & LBA28_LAST;
         case ($urandom_range(0, 4))
            0: r.num_sectors = 17'd0;
            1: r.num_sectors = COUNT28_LAST;
            2: r.num_sectors = COUNT28_LAST + 17'd1;
            3: r.num_sectors = COUNT_FULL;
            default: r.num_sectors = 17'($urandom_range(65537, 131071));
         endcase
      end else begin
         r.cmd         = 2'($urandom_range(0, 2));
         r.num_sectors = 17'($urandom);
      end
      return r;
   endfunction

   function automatic int sender_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 12);
      return $urandom_range(20, 40);
   endfunction

   // present one request and hold it until taken; start stays high for a following request
   task automatic send_request(input req_type r);
      int beats;
      start       <= 1'b1;
      req_payload <= r;
      @(negedge clock);
      while (busy) @(negedge clock);
      beats = queue_taskfile_writes(r, dma_mode_model);
      case (beats)
         0:           ignored_count++;
         BEATS_FLUSH: flush_count++;
         BEATS_LBA28: lba28_count++;
         default:     lba48_count++;
      endcase
      @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_pending();
      start <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_dma_mode(input logic mode);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      dma_mode_model = mode;
   endtask

   // all eight transfer opcodes: read and write, pio and dma, both addressing modes
   task automatic test_opcodes();
      for (int mode = 0; mode < 2; mode++) begin
         write_dma_mode(1'(mode));
         send_request(build_request(CMD_READ, 1'b0, 48'h0012_3456, 17'd8));
         send_request(build_request(CMD_WRITE, 1'b1, 48'h0765_4321, 17'd200));
         send_request(build_request(CMD_READ, 1'b1, 48'h1234_5678_9abc, 17'd16));
         send_request(build_request(CMD_WRITE, 1'b0, 48'h0000_0100, 17'd4000));
         drain_pending();
      end
   endtask

   // address and count edges, full, zero and oversize counts
   task automatic test_address_limits();
      write_dma_mode(1'b0);
      send_request(build_request(CMD_READ, 1'b0, 48'h0, 17'd1));
      send_request(build_request(CMD_READ, 1'b1, LBA28_LAST, 17'd1));
      send_request(build_request(CMD_WRITE, 1'b0, LBA28_LAST + 48'd1, 17'd1));
      send_request(build_request(CMD_READ, 1'b1, LBA_TOP, COUNT_FULL));
      send_request(build_request(CMD_WRITE, 1'b1, 48'h00ab_cdef, COUNT28_LAST));
      send_request(build_request(CMD_READ, 1'b0, 48'h5, COUNT28_LAST + 17'd1));
      send_request(build_request(CMD_READ, 1'b0, 48'h0a5a_5a5a, 17'd0));
      send_request(build_request(CMD_WRITE, 1'b1, 48'h0055_aa55, COUNT_FULL + 17'd1));
      send_request(build_request(CMD_READ, 1'b0, 48'h8000_0000_0000, COUNT_TOP));
      drain_pending();
   endtask

   // flush on both drives, and an unused code that must leave no beat behind
   task automatic test_flush_and_unused();
      write_dma_mode(1'b1);
      send_request(build_request(CMD_FLUSH, 1'b0, LBA_TOP, COUNT_TOP));
      send_request(build_request(CMD_FLUSH, 1'b1, 48'h0, 17'd0));
      send_request(build_request(CMD_UNUSED, 1'b1, LBA_TOP, COUNT_TOP));
      send_request(build_request(CMD_READ, 1'b1, 48'h0fed_cba9, 17'd3));
      drain_pending();
   endtask

   // random traffic under one dma setting, back-to-back at first, then with gaps
   task automatic test_random_traffic(input logic mode);
      req_type r;
      int      sent;
      int      gap;
      sent = 0;
      write_dma_mode(mode);
      while (sent < RANDOM_ITEMS) begin
         r = random_request();
         send_request(r);
         if (r.cmd != CMD_UNUSED) sent++;
         if (sent >= BURST_ITEMS) begin
            gap = sender_gap();
            if ($urandom_range(0, 39) == 0) drain_pending();
            else if (gap > 0) pause_sender(gap);
         end
      end
      drain_pending();
   endtask

   // result checker: every strobed beat against the oldest pending write
   always @(negedge clock) begin : beat_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         beats_checked++;
         if (pending_writes.size() == 0) begin
            note_failure($sformatf("unexpected beat target %0d value %02h last %0b",
                                   rsp_payload.target, rsp_payload.value, rsp_payload.last));
         end else begin
            want = pending_writes.pop_front();
            if (rsp_payload.target !== want.target)
               note_failure($sformatf("target expected %0d got %0d",
                                      want.target, rsp_payload.target));
            if (rsp_payload.value !== want.value)
               note_failure($sformatf("value expected %02h got %02h (target %0d)",
                                      want.value, rsp_payload.value, want.target));
            if (rsp_payload.last !== want.last)
               note_failure($sformatf("last expected %0b got %0b (target %0d)",
                                      want.last, rsp_payload.last, want.target));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("ata_taskfile_command_issuer regression: fail");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_opcodes();
      test_address_limits();
      test_flush_and_unused();
      test_random_traffic(1'b1);
      test_random_traffic(1'b0);
      test_random_traffic(1'b1);
      drain_pending();
      if (pending_writes.size() != 0)
         note_failure($sformatf("%0d writes never arrived", pending_writes.size()));
      $display("covered %0d lba28, %0d lba48 and %0d flush requests plus %0d unused codes",
               lba28_count, lba48_count, flush_count, ignored_count);
      $display("%0d beats checked over pio and dma modes, %0d failures",
               beats_checked, error_count);
      if (error_count == 0)
         $display("ata_taskfile_command_issuer regression: pass");
      else
         $display("ata_taskfile_command_issuer regression: fail");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/ata_tf_pkg.sv
rtl/core/ata_tf_builder.sv
rtl/core/ata_tf_sequencer.sv
rtl/core/ata_taskfile_command_issuer.sv
sim/testbench.sv
